// ===== rtl/core/dwmrc_pkg.sv =====
// ----------------------------------------------------------------------------
// dwmrc_pkg
// Shared widths, register indexes and types for the dual window rate checker.
// ----------------------------------------------------------------------------
package dwmrc_pkg;

  localparam int TIME_BITS    = 32;
  localparam int COUNT_BITS   = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_INTERVAL  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_LIMIT     = 2'd3;

  localparam logic [TIME_BITS-1:0]  SHORT_INTERVAL_RST = TIME_BITS'(1000);
  localparam logic [COUNT_BITS-1:0] SHORT_LIMIT_RST    = COUNT_BITS'(10);
  localparam logic [TIME_BITS-1:0]  LONG_INTERVAL_RST  = TIME_BITS'(10000);
  localparam logic [COUNT_BITS-1:0] LONG_LIMIT_RST     = COUNT_BITS'(50);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [TIME_BITS-1:0]  interval;
    logic [COUNT_BITS-1:0] limit;
  } win_cfg_t;

  typedef struct packed {
    logic                  over;
    logic                  report;
    logic [COUNT_BITS-1:0] count;
  } win_res_t;

endpackage

// ===== rtl/core/dwmrc_window.sv =====
// ----------------------------------------------------------------------------
// dwmrc_window
// One fixed window: start time, saturating counter and error mark, judged
// against one arrival per beat.
// ----------------------------------------------------------------------------
module dwmrc_window (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic [dwmrc_pkg::TIME_BITS-1:0] now,
  input  dwmrc_pkg::win_cfg_t            cfg,
  output dwmrc_pkg::win_res_t            res
);

  logic [dwmrc_pkg::TIME_BITS-1:0]  start_r, start_nxt;
  logic [dwmrc_pkg::COUNT_BITS-1:0] count_r, count_nxt, count_inc;
  logic                             flagged_r, flagged_nxt;
  logic [dwmrc_pkg::TIME_BITS-1:0]  delta;

  always_comb begin
    count_inc   = (count_r == dwmrc_pkg::COUNT_MAX) ? count_r
                                                    : count_r + 1'b1;
    delta       = now - start_r;
    start_nxt   = start_r;
    count_nxt   = count_inc;
    flagged_nxt = flagged_r;
    res.over    = 1'b0;
    res.report  = 1'b0;
    if (delta > cfg.interval) begin
      start_nxt   = now;
      count_nxt   = '0;
      flagged_nxt = 1'b0;
    end else if (count_inc > cfg.limit) begin
      res.over    = 1'b1;
      res.report  = !flagged_r;
      flagged_nxt = 1'b1;
    end
    res.count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      count_r   <= '0;
      flagged_r <= 1'b0;
    end else if (adv) begin
      start_r   <= start_nxt;
      count_r   <= count_nxt;
      flagged_r <= flagged_nxt;
    end
  end

endmodule

// ===== rtl/core/dual_window_message_rate_checker_core.sv =====
// ----------------------------------------------------------------------------
// dual_window_message_rate_checker_core
// Short and long fixed window message rate checker, one result per message.
// ----------------------------------------------------------------------------
// An accepted beat enters the input register and its result the result
// register. Throughput: one beat per cycle while out_stall is low. Each
// window does one subtract, compare and counter update between them.
// Reset (rst_n low, synchronous): windows start at zero with empty counters,
// registers return to 1000/10/10000/50, both stages empty.
// ----------------------------------------------------------------------------
module dual_window_message_rate_checker_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dwmrc_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [dwmrc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dwmrc_pkg::TIME_BITS-1:0]     in_arrival_time,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_accepted,
  output logic                                out_short_over,
  output logic                                out_long_over,
  output logic                                out_short_report,
  output logic                                out_long_report,
  output logic [dwmrc_pkg::COUNT_BITS-1:0]    out_short_count_out,
  output logic [dwmrc_pkg::COUNT_BITS-1:0]    out_long_count_out
);

  dwmrc_pkg::win_cfg_t short_cfg_r, long_cfg_r;
  dwmrc_pkg::win_res_t short_res, long_res;

  logic                             s1_valid_r;
  logic [dwmrc_pkg::TIME_BITS-1:0]  s1_time_r;
  logic                             out_valid_r;
  logic                             adv;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_cfg_r.interval <= dwmrc_pkg::SHORT_INTERVAL_RST;
      short_cfg_r.limit    <= dwmrc_pkg::SHORT_LIMIT_RST;
      long_cfg_r.interval  <= dwmrc_pkg::LONG_INTERVAL_RST;
      long_cfg_r.limit     <= dwmrc_pkg::LONG_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        dwmrc_pkg::REG_SHORT_INTERVAL:
          short_cfg_r.interval <= cfg_wdata[dwmrc_pkg::TIME_BITS-1:0];
        dwmrc_pkg::REG_SHORT_LIMIT:
          short_cfg_r.limit <= cfg_wdata[dwmrc_pkg::COUNT_BITS-1:0];
        dwmrc_pkg::REG_LONG_INTERVAL:
          long_cfg_r.interval <= cfg_wdata[dwmrc_pkg::TIME_BITS-1:0];
        dwmrc_pkg::REG_LONG_LIMIT:
          long_cfg_r.limit <= cfg_wdata[dwmrc_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // advance the input stage into the result register
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_stall ? 1'b1 : in_valid;
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_time_r <= in_arrival_time;
    end
  end

  dwmrc_window u_short (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .now   (s1_time_r),
    .cfg   (short_cfg_r),
    .res   (short_res)
  );

  dwmrc_window u_long (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .now   (s1_time_r),
    .cfg   (long_cfg_r),
    .res   (long_res)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      out_accepted        <= !(short_res.over || long_res.over);
      out_short_over      <= short_res.over;
      out_long_over       <= long_res.over;
      out_short_report    <= short_res.report;
      out_long_report     <= long_res.report;
      out_short_count_out <= short_res.count;
      out_long_count_out  <= long_res.count;
    end
  end

  assign out_valid = out_valid_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input stage");

  a_accept_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_accepted == !(out_short_over || out_long_over)))
    else $error("accepted flag disagrees with over flags");

  a_report_implies_over: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!out_short_report || out_short_over) &&
                     (!out_long_report || out_long_over)))
    else $error("report without violation");

  a_over_nonzero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_short_over) |-> (out_short_count_out != '0))
    else $error("short violation with zero count");

endmodule

// ===== tb/sv/dual_window_message_rate_checker_core_tb.sv =====
// ----------------------------------------------------------------------------
// dual_window_message_rate_checker_core_tb
// Drives timestamped message beats into the dual window rate checker and
// checks every result beat against a cycle-free prediction of both windows.
// The run covers several register settings: tiny windows, zero limits,
// full-range intervals and limits. It also has a long receiver hold-off and
// ends with a back-to-back burst with no idling on either side.
// ----------------------------------------------------------------------------
module dual_window_message_rate_checker_core_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int FINAL_BEATS = 100;

  typedef struct packed {
    logic                             accepted;
    logic                             short_over;
    logic                             long_over;
    logic                             short_report;
    logic                             long_report;
    logic [dwmrc_pkg::COUNT_BITS-1:0] short_count;
    logic [dwmrc_pkg::COUNT_BITS-1:0] long_count;
  } rate_verdict_t;

  typedef struct packed {
    logic [dwmrc_pkg::TIME_BITS-1:0]  start;
    logic [dwmrc_pkg::COUNT_BITS-1:0] count;
    logic                             flagged;
  } window_state_t;

  class rate_window_tracker;
    logic [dwmrc_pkg::TIME_BITS-1:0]  short_interval;
    logic [dwmrc_pkg::COUNT_BITS-1:0] short_limit;
    logic [dwmrc_pkg::TIME_BITS-1:0]  long_interval;
    logic [dwmrc_pkg::COUNT_BITS-1:0] long_limit;
    window_state_t                    short_win;
    window_state_t                    long_win;
    rate_verdict_t                    pending_verdicts[$];
    int                               mismatches;

    function new();
      short_interval = dwmrc_pkg::SHORT_INTERVAL_RST;
      short_limit    = dwmrc_pkg::SHORT_LIMIT_RST;
      long_interval  = dwmrc_pkg::LONG_INTERVAL_RST;
      long_limit     = dwmrc_pkg::LONG_LIMIT_RST;
      short_win      = '0;
      long_win       = '0;
      mismatches     = 0;
    endfunction

    function void set_reg(logic [dwmrc_pkg::CFG_IDX_BITS-1:0] idx,
                          logic [dwmrc_pkg::CFG_DATA_BITS-1:0] data);
      case (idx)
        dwmrc_pkg::REG_SHORT_INTERVAL: short_interval = data[dwmrc_pkg::TIME_BITS-1:0];
        dwmrc_pkg::REG_SHORT_LIMIT:    short_limit    = data[dwmrc_pkg::COUNT_BITS-1:0];
        dwmrc_pkg::REG_LONG_INTERVAL:  long_interval  = data[dwmrc_pkg::TIME_BITS-1:0];
        dwmrc_pkg::REG_LONG_LIMIT:     long_limit     = data[dwmrc_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function window_state_t judge_window(window_state_t w,
                                         logic [dwmrc_pkg::TIME_BITS-1:0] now,
                                         logic [dwmrc_pkg::TIME_BITS-1:0] interval,
                                         logic [dwmrc_pkg::COUNT_BITS-1:0] limit,
                                         output logic over, output logic report);
      logic [dwmrc_pkg::TIME_BITS-1:0] elapsed;
      elapsed = now - w.start;
      over    = 1'b0;
      report  = 1'b0;
      if (elapsed > interval) begin
        w.start   = now;
        w.count   = '0;
        w.flagged = 1'b0;
      end else if (w.count > limit) begin
        over      = 1'b1;
        report    = !w.flagged;
        w.flagged = 1'b1;
      end
      return w;
    endfunction

    function void log_arrival(logic [dwmrc_pkg::TIME_BITS-1:0] now);
      rate_verdict_t v;
      if (short_win.count != dwmrc_pkg::COUNT_MAX) short_win.count++;
      if (long_win.count != dwmrc_pkg::COUNT_MAX) long_win.count++;
      short_win = judge_window(short_win, now, short_interval, short_limit,
                               v.short_over, v.short_report);
      long_win  = judge_window(long_win, now, long_interval, long_limit,
                               v.long_over, v.long_report);
      v.accepted    = !(v.short_over | v.long_over);
      v.short_count = short_win.count;
      v.long_count  = long_win.count;
      pending_verdicts.push_back(v);
    endfunction

    function void report_mismatch(string what, rate_verdict_t e, rate_verdict_t g);
      mismatches++;
      if (mismatches <= 10) begin
        $display("MISMATCH %s: exp acc=%0b so=%0b lo=%0b sr=%0b lr=%0b sc=%0d lc=%0d",
                 what, e.accepted, e.short_over, e.long_over, e.short_report,
                 e.long_report, e.short_count, e.long_count);
        $display("         %s: got acc=%0b so=%0b lo=%0b sr=%0b lr=%0b sc=%0d lc=%0d",
                 what, g.accepted, g.short_over, g.long_over, g.short_report,
                 g.long_report, g.short_count, g.long_count);
      end
    endfunction

    function void check_verdict(rate_verdict_t got);
      rate_verdict_t e;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected beat", '0, got);
        return;
      end
      e = pending_verdicts.pop_front();
      if (got.accepted !== e.accepted || got.short_over !== e.short_over ||
          got.long_over !== e.long_over || got.short_report !== e.short_report ||
          got.long_report !== e.long_report || got.short_count !== e.short_count ||
          got.long_count !== e.long_count)
        report_mismatch("result field", e, got);
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [dwmrc_pkg::CFG_IDX_BITS-1:0]  cfg_idx = '0;
  logic [dwmrc_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [dwmrc_pkg::TIME_BITS-1:0]     in_arrival_time = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic                                out_accepted;
  logic                                out_short_over;
  logic                                out_long_over;
  logic                                out_short_report;
  logic                                out_long_report;
  logic [dwmrc_pkg::COUNT_BITS-1:0]    out_short_count_out;
  logic [dwmrc_pkg::COUNT_BITS-1:0]    out_long_count_out;

  rate_window_tracker book;
  bit                 src_idle = 1'b0;
  bit                 sink_idle = 1'b1;
  bit                 hold_req = 1'b0;
  int                 cycle_count = 0;

  dual_window_message_rate_checker_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_arrival_time     (in_arrival_time),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_accepted        (out_accepted),
    .out_short_over      (out_short_over),
    .out_long_over       (out_long_over),
    .out_short_report    (out_short_report),
    .out_long_report     (out_long_report),
    .out_short_count_out (out_short_count_out),
    .out_long_count_out  (out_long_count_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_arrival(input logic [dwmrc_pkg::TIME_BITS-1:0] stamp);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_arrival_time <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.log_arrival(stamp);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [dwmrc_pkg::TIME_BITS-1:0]  si,
                                input logic [dwmrc_pkg::COUNT_BITS-1:0] sl,
                                input logic [dwmrc_pkg::TIME_BITS-1:0]  li,
                                input logic [dwmrc_pkg::COUNT_BITS-1:0] ll);
    logic [dwmrc_pkg::CFG_IDX_BITS-1:0]  idxs [4];
    logic [dwmrc_pkg::CFG_DATA_BITS-1:0] vals [4];
    idxs = '{dwmrc_pkg::REG_SHORT_INTERVAL, dwmrc_pkg::REG_SHORT_LIMIT,
             dwmrc_pkg::REG_LONG_INTERVAL, dwmrc_pkg::REG_LONG_LIMIT};
    // junk in the upper bits of the limit writes must be dropped
    vals = '{si, {16'($urandom), sl}, li, {16'($urandom), ll}};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idxs[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
      book.set_reg(idxs[k], vals[k]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [dwmrc_pkg::TIME_BITS-1:0] next_arrival(
      logic [dwmrc_pkg::TIME_BITS-1:0] cur);
    longint unsigned span;
    int unsigned     pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0: return $urandom;
      1: return cur - $urandom_range(1, 2000);
      2: return cur + book.short_interval + $urandom_range(0, 2);
      3: return cur + book.long_interval + $urandom_range(0, 2);
      default: begin
        if (pick < 8)
          span = (64'(book.long_interval) * 64'd2) / (64'(book.long_limit) + 64'd1);
        else
          span = (64'(book.short_interval) * 64'd2) / (64'(book.short_limit) + 64'd1);
        if (span < 64'd1) span = 64'd1;
        if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
        return cur + $urandom_range(0, 32'(span));
      end
    endcase
  endfunction

  task automatic run_random(input int beats);
    logic [dwmrc_pkg::TIME_BITS-1:0] cur;
    cur = $urandom;
    repeat (beats) begin
      cur = next_arrival(cur);
      send_arrival(cur);
    end
  endtask

  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rate_verdict_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.accepted     = out_accepted;
      got.short_over   = out_short_over;
      got.long_over    = out_long_over;
      got.short_report = out_short_report;
      got.long_report  = out_long_report;
      got.short_count  = out_short_count_out;
      got.long_count   = out_long_count_out;
      book.check_verdict(got);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [dwmrc_pkg::TIME_BITS-1:0] directed_times [$];
    book = new();
    directed_times = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8,
                       32'd9, 32'd10, 32'd11, 32'd1001, 32'hFFFF_FFFF, 32'h0000_0010,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: fill the short window, repeat the violation, restart, wrap
    foreach (directed_times[i]) send_arrival(directed_times[i]);
    drain();

    src_idle = 1'b1;
    apply_settings(32'd1, 16'd0, 32'd5, 16'd2);
    run_random(250);
    drain();

    apply_settings(32'd100, 16'd3, 32'd1000, 16'd20);
    run_random(120);
    src_idle = 1'b0;
    hold_req = 1'b1;
    run_random(80);
    src_idle = 1'b1;
    run_random(100);
    drain();

    repeat (3) begin
      apply_settings(32'($urandom_range(1, 5000)), 16'($urandom_range(0, 40)),
                     32'($urandom_range(1, 200000)), 16'($urandom_range(0, 400)));
      run_random(170);
      drain();
    end

    apply_settings(32'hFFFF_FFFF, 16'hFFFF, 32'd1, 16'd0);
    run_random(150);
    drain();

    // no idling from here on
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    apply_settings(32'd50, 16'd4, 32'd400, 16'd12);
    run_random(FINAL_BEATS);
    drain();

    if (book.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
